// ----- hw/rtl/rsi_pkg.sv -----
// Shared widths and constants for the ray/sphere intersection pipeline.
`default_nettype none
package rsi_pkg;

    localparam int FRAC_BITS_DEF = 16;

    // field widths
    localparam int COORD_W   = 32;
    localparam int RAD_W     = 31;
    localparam int DIST_W    = 31;
    localparam int S_TDATA_W = 320;
    localparam int M_TDATA_W = 32;

    // quadratic terms: A = d.d, B = d.x, C = x.x - r*r
    localparam int X_W    = COORD_W + 1;
    localparam int A_W    = 2 * COORD_W;
    localparam int B_W    = 66;
    localparam int C_W    = 67;

    // wide products B*B and A*C
    localparam int MUL_W     = 67;
    localparam int MUL_DIG_W = 16;
    localparam int PROD_W    = 2 * MUL_W;

    // discriminant and its root
    localparam int ROOT_W = 66;
    localparam int RADC_W = 2 * ROOT_W;
    localparam int N_W    = 68;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

endpackage
`default_nettype wire

// ----- hw/rtl/rsi_mul.sv -----
// Pipelined unsigned multiplier, one digit of the second operand per stage.
`default_nettype none
module rsi_mul #(
    parameter int AW = rsi_pkg::MUL_W,
    parameter int BW = rsi_pkg::MUL_W,
    parameter int DW = rsi_pkg::MUL_DIG_W,
    parameter int SW = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [AW-1:0]    a,
    input  logic [BW-1:0]    b,
    input  logic [SW-1:0]    side,
    output logic             out_valid,
    output logic [AW+BW-1:0] p,
    output logic [SW-1:0]    side_out
);

    localparam int NSTG = (BW + DW - 1) / DW;
    localparam int BWP  = NSTG * DW;
    localparam int PW   = AW + BWP;

    logic          v_reg    [0:NSTG-1];
    logic [AW-1:0] a_reg    [0:NSTG-1];
    logic [BWP-1:0] b_reg   [0:NSTG-1];
    logic [PW-1:0] acc_reg  [0:NSTG-1];
    logic [SW-1:0] side_reg [0:NSTG-1];

    for (genvar k = 0; k < NSTG; k++)
    begin : g_stg
        logic           v_prev;
        logic [AW-1:0]  a_prev;
        logic [BWP-1:0] b_prev;
        logic [PW-1:0]  acc_prev;
        logic [SW-1:0]  s_prev;
        logic [AW+DW-1:0] pp;

        if (k == 0)
        begin : g_first
            assign v_prev   = in_valid;
            assign a_prev   = a;
            assign b_prev   = BWP'(b);
            assign acc_prev = '0;
            assign s_prev   = side;
        end
        else
        begin : g_next
            assign v_prev   = v_reg[k-1];
            assign a_prev   = a_reg[k-1];
            assign b_prev   = b_reg[k-1];
            assign acc_prev = acc_reg[k-1];
            assign s_prev   = side_reg[k-1];
        end

        assign pp = {{DW{1'b0}}, a_prev} * {{AW{1'b0}}, b_prev[k*DW +: DW]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                a_reg[k]    <= a_prev;
                b_reg[k]    <= b_prev;
                acc_reg[k]  <= acc_prev + (PW'(pp) << (k * DW));
                side_reg[k] <= s_prev;
            end
        end
    end

    assign out_valid = v_reg[NSTG-1];
    assign p         = acc_reg[NSTG-1][AW+BW-1:0];
    assign side_out  = side_reg[NSTG-1];

endmodule
`default_nettype wire

// ----- hw/rtl/rsi_sqrt.sv -----
// Pipelined integer floor square root, one root bit per stage.
`default_nettype none
module rsi_sqrt #(
    parameter int RW = rsi_pkg::ROOT_W,
    parameter int SW = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [2*RW-1:0] radicand,
    input  logic [SW-1:0]   side,
    output logic            out_valid,
    output logic [RW-1:0]   root,
    output logic [SW-1:0]   side_out
);

    localparam int REMW = RW + 2;

    logic            v_reg    [0:RW-1];
    logic [REMW-1:0] rem_reg  [0:RW-1];
    logic [RW-1:0]   root_reg [0:RW-1];
    logic [2*RW-1:0] rad_reg  [0:RW-1];
    logic [SW-1:0]   side_reg [0:RW-1];

    for (genvar k = 0; k < RW; k++)
    begin : g_stg
        logic            v_prev;
        logic [REMW-1:0] rem_prev;
        logic [RW-1:0]   root_prev;
        logic [2*RW-1:0] rad_prev;
        logic [SW-1:0]   s_prev;
        logic [REMW+1:0] rem_sh;
        logic [REMW+1:0] trial;
        logic            ge;

        if (k == 0)
        begin : g_first
            assign v_prev    = in_valid;
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign rad_prev  = radicand;
            assign s_prev    = side;
        end
        else
        begin : g_next
            assign v_prev    = v_reg[k-1];
            assign rem_prev  = rem_reg[k-1];
            assign root_prev = root_reg[k-1];
            assign rad_prev  = rad_reg[k-1];
            assign s_prev    = side_reg[k-1];
        end

        // bring down two radicand bits, try root*4+1
        assign rem_sh = {rem_prev, rad_prev[2*RW-1 -: 2]};
        assign trial  = {2'b00, root_prev, 2'b01};
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= ge ? REMW'(rem_sh - trial) : REMW'(rem_sh);
                root_reg[k] <= {root_prev[RW-2:0], ge};
                rad_reg[k]  <= rad_prev << 2;
                side_reg[k] <= s_prev;
            end
        end
    end

    assign out_valid = v_reg[RW-1];
    assign root      = root_reg[RW-1];
    assign side_out  = side_reg[RW-1];

endmodule
`default_nettype wire

// ----- hw/rtl/ray_sphere_intersect.sv -----
// Ray/sphere intersection: fully pipelined quadratic solve in exact fixed point.
//
// Input stream (s_axis_*): one ray/sphere test per transfer. Origin, direction
// and centre are signed Q(32-FRAC_BITS).FRAC_BITS, radius unsigned, 31 bits.
// Output stream (m_axis_*): one result per test, in input order. tuser is the
// hit flag; tdata is the nearest non-negative distance t (0 on a miss),
// saturated at 0x7FFFFFFF.
// Throughput: one transfer per cycle in each direction while no stall holds the
// pipeline. Its depth comes from the 66-stage square root (one root bit per
// stage), the 31-stage divider (one quotient bit per stage) and the 5-stage
// 67x67 multipliers (16-bit digit per stage).
// Stall: the whole pipeline shares one enable. A result that finds the output
// register full and not taken lands in a skid register; only while the skid
// register is full does the pipeline freeze and s_axis_tready drop. s_axis_tready
// depends on registers only, never combinationally on m_axis_tready.
// Reset: rst_n clears all valid bits; the block is then empty and ready. There
// is no other state and no configuration.
`default_nettype none
module ray_sphere_intersect #(
    parameter int FRAC_BITS = rsi_pkg::FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // ray_origin_x/y/z, ray_dir_x/y/z, centre_x/y/z (32 each), sphere_radius (31), 1 pad
    input  logic [rsi_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // distance (31), 1 pad
    output logic [rsi_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // hit
    output logic [0:0]                      m_axis_tuser
);

    localparam int CW32   = rsi_pkg::COORD_W;
    localparam int X_W    = rsi_pkg::X_W;
    localparam int A_W    = rsi_pkg::A_W;
    localparam int B_W    = rsi_pkg::B_W;
    localparam int C_W    = rsi_pkg::C_W;
    localparam int MUL_W  = rsi_pkg::MUL_W;
    localparam int PROD_W = rsi_pkg::PROD_W;
    localparam int ROOT_W = rsi_pkg::ROOT_W;
    localparam int RADC_W = rsi_pkg::RADC_W;
    localparam int N_W    = rsi_pkg::N_W;
    localparam int DIST_W = rsi_pkg::DIST_W;
    // scaled numerator n * 2^FRAC_BITS, n below 2^67
    localparam int NUM_W  = N_W - 1 + FRAC_BITS;
    localparam int DEN_W  = A_W + DIST_W;
    localparam int CMP_W  = ((NUM_W > DEN_W) ? NUM_W : DEN_W) + 1;
    localparam int SQ_SW  = A_W + B_W + 1;

    // one shared advance for every stage
    logic en;
    logic out_valid_reg;
    logic skid_valid_reg;

    assign en            = !skid_valid_reg;
    assign s_axis_tready = en;

    // ---------------- stage 1: unpack, x = o - c
    logic                   s1_v_reg;
    logic signed [CW32-1:0] s1_d_reg [0:2];
    logic signed [X_W-1:0]  s1_x_reg [0:2];
    logic [rsi_pkg::RAD_W-1:0] s1_r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg <= s_axis_tvalid;
        end
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_s1
        logic signed [CW32-1:0] o_f;
        logic signed [CW32-1:0] c_f;

        assign o_f = s_axis_tdata[i*CW32 +: CW32];
        assign c_f = s_axis_tdata[(6+i)*CW32 +: CW32];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                s1_d_reg[i] <= s_axis_tdata[(3+i)*CW32 +: CW32];
                s1_x_reg[i] <= X_W'(o_f) - X_W'(c_f);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_r_reg <= s_axis_tdata[9*CW32 +: rsi_pkg::RAD_W];
        end
    end

    // ---------------- stage 2: component products
    logic                      s2_v_reg;
    logic signed [A_W-1:0]     s2_dd_reg [0:2];
    logic signed [A_W:0]       s2_dx_reg [0:2];
    logic signed [2*X_W-1:0]   s2_xx_reg [0:2];
    logic [2*rsi_pkg::RAD_W-1:0] s2_rr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_v_reg <= s1_v_reg;
        end
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_s2
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                s2_dd_reg[i] <= s1_d_reg[i] * s1_d_reg[i];
                s2_dx_reg[i] <= s1_d_reg[i] * s1_x_reg[i];
                s2_xx_reg[i] <= s1_x_reg[i] * s1_x_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_rr_reg <= s1_r_reg * s1_r_reg;
        end
    end

    // ---------------- stage 3: A, B, C and magnitudes
    logic signed [B_W-1:0] b_sum;
    logic signed [C_W-1:0] c_sum;
    logic                  s3_v_reg;
    logic [A_W-1:0]        s3_a_reg;
    logic signed [B_W-1:0] s3_b_reg;
    logic [MUL_W-1:0]      s3_bmag_reg;
    logic [MUL_W-1:0]      s3_cmag_reg;
    logic                  s3_cneg_reg;

    assign b_sum = s2_dx_reg[0] + s2_dx_reg[1] + s2_dx_reg[2];
    assign c_sum = s2_xx_reg[0] + s2_xx_reg[1] + s2_xx_reg[2]
                 - $signed({1'b0, s2_rr_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_a_reg    <= A_W'(s2_dd_reg[0] + s2_dd_reg[1] + s2_dd_reg[2]);
            s3_b_reg    <= b_sum;
            s3_bmag_reg <= b_sum[B_W-1] ? MUL_W'(-b_sum) : MUL_W'(b_sum);
            s3_cmag_reg <= c_sum[C_W-1] ? MUL_W'(-c_sum) : MUL_W'(c_sum);
            s3_cneg_reg <= c_sum[C_W-1];
        end
    end

    // ---------------- B*B and A*C
    logic              bb_v;
    logic              ac_v;
    logic [PROD_W-1:0] bb_p;
    logic [PROD_W-1:0] ac_p;
    logic [A_W+B_W-1:0] bb_side;
    logic [0:0]        ac_side;

    rsi_mul #(
        .AW (MUL_W),
        .BW (MUL_W),
        .DW (rsi_pkg::MUL_DIG_W),
        .SW (A_W + B_W)
    ) u_mul_bb (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s3_v_reg),
        .a         (s3_bmag_reg),
        .b         (s3_bmag_reg),
        .side      ({s3_a_reg, s3_b_reg}),
        .out_valid (bb_v),
        .p         (bb_p),
        .side_out  (bb_side)
    );

    rsi_mul #(
        .AW (MUL_W),
        .BW (MUL_W),
        .DW (rsi_pkg::MUL_DIG_W),
        .SW (1)
    ) u_mul_ac (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s3_v_reg),
        .a         (MUL_W'(s3_a_reg)),
        .b         (s3_cmag_reg),
        .side      (s3_cneg_reg),
        .out_valid (ac_v),
        .p         (ac_p),
        .side_out  (ac_side)
    );

    // ---------------- discriminant D = B*B - A*C
    logic signed [PROD_W+1:0] disc;
    logic [A_W-1:0]           m_a;
    logic                     sd_v_reg;
    logic [RADC_W-1:0]        sd_rad_reg;
    logic [SQ_SW-1:0]         sd_side_reg;

    assign m_a  = bb_side[B_W +: A_W];
    assign disc = ac_side[0] ? $signed({2'b00, bb_p}) + $signed({2'b00, ac_p})
                             : $signed({2'b00, bb_p}) - $signed({2'b00, ac_p});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sd_v_reg <= 1'b0;
        end
        else if (en)
        begin
            sd_v_reg <= bb_v & ac_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // a negative discriminant or a zero direction is a miss
            sd_rad_reg  <= disc[PROD_W+1] ? '0 : disc[RADC_W-1:0];
            sd_side_reg <= {m_a, bb_side[B_W-1:0], (disc[PROD_W+1] || (m_a == '0))};
        end
    end

    // ---------------- s = floor(sqrt(D))
    logic              sq_v;
    logic [ROOT_W-1:0] sq_root;
    logic [SQ_SW-1:0]  sq_side;

    rsi_sqrt #(
        .RW (ROOT_W),
        .SW (SQ_SW)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sd_v_reg),
        .radicand  (sd_rad_reg),
        .side      (sd_side_reg),
        .out_valid (sq_v),
        .root      (sq_root),
        .side_out  (sq_side)
    );

    // ---------------- root choice: -B - s, else -B + s
    logic signed [N_W-1:0] b_ext;
    logic signed [N_W-1:0] s_ext;
    logic signed [N_W-1:0] n_near;
    logic signed [N_W-1:0] n_far;
    logic                  sn_v_reg;
    logic [NUM_W-1:0]      sn_num_reg;
    logic [A_W-1:0]        sn_a_reg;
    logic                  sn_miss_reg;

    assign b_ext  = N_W'(signed'(sq_side[B_W:1]));
    assign s_ext  = {2'b00, sq_root};
    assign n_near = -b_ext - s_ext;
    assign n_far  = -b_ext + s_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sn_v_reg <= 1'b0;
        end
        else if (en)
        begin
            sn_v_reg <= sq_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sn_a_reg    <= sq_side[B_W+1 +: A_W];
            sn_miss_reg <= sq_side[0] || (n_near[N_W-1] && n_far[N_W-1]);
            if (!n_near[N_W-1])
            begin
                sn_num_reg <= {n_near[N_W-2:0], {FRAC_BITS{1'b0}}};
            end
            else
            begin
                sn_num_reg <= {n_far[N_W-2:0], {FRAC_BITS{1'b0}}};
            end
        end
    end

    // ---------------- saturation check: num >= A * 2^31
    logic             ss_v_reg;
    logic [NUM_W-1:0] ss_num_reg;
    logic [A_W-1:0]   ss_a_reg;
    logic             ss_miss_reg;
    logic             ss_sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ss_v_reg <= 1'b0;
        end
        else if (en)
        begin
            ss_v_reg <= sn_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ss_num_reg  <= sn_num_reg;
            ss_a_reg    <= sn_a_reg;
            ss_miss_reg <= sn_miss_reg;
            ss_sat_reg  <= (CMP_W'(sn_num_reg) >= (CMP_W'(sn_a_reg) << DIST_W));
        end
    end

    // ---------------- restoring divide, quotient bit DIST_W-1-j in stage j
    logic              dv_v_reg    [0:DIST_W-1];
    logic [NUM_W-1:0]  dv_rem_reg  [0:DIST_W-1];
    logic [A_W-1:0]    dv_a_reg    [0:DIST_W-1];
    logic [DIST_W-1:0] dv_q_reg    [0:DIST_W-1];
    logic              dv_miss_reg [0:DIST_W-1];
    logic              dv_sat_reg  [0:DIST_W-1];

    for (genvar j = 0; j < DIST_W; j++)
    begin : g_div
        localparam int QB = DIST_W - 1 - j;
        logic              v_prev;
        logic [NUM_W-1:0]  rem_prev;
        logic [A_W-1:0]    a_prev;
        logic [DIST_W-1:0] q_prev;
        logic              miss_prev;
        logic              sat_prev;
        logic [CMP_W-1:0]  sub;
        logic              ge;

        if (j == 0)
        begin : g_first
            assign v_prev    = ss_v_reg;
            assign rem_prev  = ss_num_reg;
            assign a_prev    = ss_a_reg;
            assign q_prev    = '0;
            assign miss_prev = ss_miss_reg;
            assign sat_prev  = ss_sat_reg;
        end
        else
        begin : g_next
            assign v_prev    = dv_v_reg[j-1];
            assign rem_prev  = dv_rem_reg[j-1];
            assign a_prev    = dv_a_reg[j-1];
            assign q_prev    = dv_q_reg[j-1];
            assign miss_prev = dv_miss_reg[j-1];
            assign sat_prev  = dv_sat_reg[j-1];
        end

        assign sub = CMP_W'(a_prev) << QB;
        assign ge  = (CMP_W'(rem_prev) >= sub);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_v_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                dv_v_reg[j] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_rem_reg[j]  <= ge ? NUM_W'(CMP_W'(rem_prev) - sub) : rem_prev;
                dv_a_reg[j]    <= a_prev;
                dv_q_reg[j]    <= q_prev | (DIST_W'(ge) << QB);
                dv_miss_reg[j] <= miss_prev;
                dv_sat_reg[j]  <= sat_prev;
            end
        end
    end

    // ---------------- output register and skid register
    logic              pipe_v;
    logic              pipe_hit;
    logic [DIST_W-1:0] pipe_dist;
    logic              out_hit_reg;
    logic [DIST_W-1:0] out_dist_reg;
    logic              skid_hit_reg;
    logic [DIST_W-1:0] skid_dist_reg;

    assign pipe_v    = dv_v_reg[DIST_W-1];
    assign pipe_hit  = !dv_miss_reg[DIST_W-1];
    assign pipe_dist = dv_miss_reg[DIST_W-1] ? '0 :
                       dv_sat_reg[DIST_W-1]  ? rsi_pkg::DIST_MAX : dv_q_reg[DIST_W-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!skid_valid_reg)
        begin
            if (pipe_v)
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
        else if (m_axis_tready)
        begin
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_valid_reg)
        begin
            if (pipe_v && (!out_valid_reg || m_axis_tready))
            begin
                out_hit_reg  <= pipe_hit;
                out_dist_reg <= pipe_dist;
            end
            else if (pipe_v)
            begin
                skid_hit_reg  <= pipe_hit;
                skid_dist_reg <= pipe_dist;
            end
        end
        else if (m_axis_tready)
        begin
            out_hit_reg  <= skid_hit_reg;
            out_dist_reg <= skid_dist_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = rsi_pkg::M_TDATA_W'(out_dist_reg);
    assign m_axis_tuser  = out_hit_reg;

    // ---------------- checks
    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full while output register empty");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (pipe_v && !skid_valid_reg && out_valid_reg && !m_axis_tready) |=> skid_valid_reg)
        else $error("stalled result not caught by skid register");

    a_skid_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_axis_tready))
        else $error("skid register filled without an output stall");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("miss carries a nonzero distance");

endmodule
`default_nettype wire

// ----- verif/tb_ray_sphere_intersect.sv -----
// Testbench for ray_sphere_intersect: exact predictor, scoreboard and random stream drivers.
`default_nettype none
module tb_ray_sphere_intersect;
    localparam int COORD_W       = rsi_pkg::COORD_W;
    localparam int RAD_W         = rsi_pkg::RAD_W;
    localparam int DIST_W        = rsi_pkg::DIST_W;
    localparam int S_TDATA_W     = rsi_pkg::S_TDATA_W;
    localparam int M_TDATA_W     = rsi_pkg::M_TDATA_W;
    localparam int FRAC_BITS_DEF = rsi_pkg::FRAC_BITS_DEF;
    localparam logic [DIST_W-1:0] DIST_MAX = rsi_pkg::DIST_MAX;

    typedef logic signed [COORD_W-1:0] coord_t;

    // one ray/sphere test as carried on s_axis_tdata
    typedef struct packed {
        logic                 pad;
        logic [RAD_W-1:0]     sphere_radius;
        coord_t               centre_z;
        coord_t               centre_y;
        coord_t               centre_x;
        coord_t               ray_dir_z;
        coord_t               ray_dir_y;
        coord_t               ray_dir_x;
        coord_t               ray_origin_z;
        coord_t               ray_origin_y;
        coord_t               ray_origin_x;
    } ray_test_t;

    typedef struct packed {
        logic                 hit;
        logic [DIST_W-1:0]    distance;
    } hit_result_t;

    // exact solve of the half-b quadratic at 192-bit width
    function automatic hit_result_t solve_ray_sphere(ray_test_t t);
        logic signed [191:0] a_q, b_q, c_q, disc, dx, xx, rr, neg_b, num, quo;
        logic [191:0] root, trial;
        hit_result_t res;
        coord_t o [3];
        coord_t d [3];
        coord_t cc [3];
        o  = '{t.ray_origin_x, t.ray_origin_y, t.ray_origin_z};
        d  = '{t.ray_dir_x, t.ray_dir_y, t.ray_dir_z};
        cc = '{t.centre_x, t.centre_y, t.centre_z};
        res = '0;
        a_q = 0; b_q = 0; c_q = 0;
        for (int i = 0; i < 3; i++)
        begin
            dx = 192'(d[i]);
            xx = 192'(o[i]) - 192'(cc[i]);
            a_q += dx * dx;
            b_q += dx * xx;
            c_q += xx * xx;
        end
        rr = {161'd0, t.sphere_radius};
        c_q -= rr * rr;
        if (a_q == 0)
            return res;
        disc = b_q * b_q - a_q * c_q;
        if (disc < 0)
            return res;
        root = 0;
        for (int bit_i = 67; bit_i >= 0; bit_i--)
        begin
            trial = root | (192'd1 << bit_i);
            if (trial * trial <= disc)
                root = trial;
        end
        neg_b = -b_q;
        if (neg_b - $signed(root) >= 0)
            num = neg_b - $signed(root);
        else if (neg_b + $signed(root) >= 0)
            num = neg_b + $signed(root);
        else
            return res;
        quo = (num <<< FRAC_BITS_DEF) / a_q;
        res.hit = 1'b1;
        res.distance = (quo >= 192'sd2147483648) ? DIST_MAX : quo[DIST_W-1:0];
        return res;
    endfunction

    class hit_scoreboard;
        hit_result_t pending[$];
        int errors;
        int checked;
        int hits;

        function void note_test(ray_test_t t);
            pending.push_back(solve_ray_sphere(t));
        endfunction

        function void check_result(hit_result_t got);
            hit_result_t exp_r;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: unexpected result hit=%0d dist=%h", got.hit, got.distance);
                return;
            end
            exp_r = pending.pop_front();
            checked++;
            if (got.hit)
                hits++;
            if (got.hit !== exp_r.hit || got.distance !== exp_r.distance)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: result %0d exp hit=%0d dist=%h got hit=%0d dist=%h",
                             checked, exp_r.hit, exp_r.distance, got.hit, got.distance);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [0:0] m_axis_tuser;

    int src_idle_pct = 0;   // percent of cycles the source holds off
    int snk_stall_pct = 0;  // percent of cycles the sink stalls
    hit_scoreboard sb;

    always #5 clk = ~clk;

    ray_sphere_intersect DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // sink: random stalls, check on each completed transfer
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result({m_axis_tuser[0], m_axis_tdata[DIST_W-1:0]});
        m_axis_tready <= rst_n && ($urandom_range(99) >= snk_stall_pct);
    end

    // drive one test; valid stays high across back-to-back transfers
    task automatic send_test(ray_test_t t);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= t;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_test(t);
    endtask

    function automatic coord_t rand_coord(int mode);
        case (mode)
            0: return coord_t'($urandom);
            1: return coord_t'($signed($urandom_range(2 * 65536 * 40)) - 65536 * 40);
            default: return coord_t'($signed($urandom_range(2 * 512)) - 512);
        endcase
    endfunction

    // mostly scene-scale rays, half of them aimed near a sphere, some fully random bits
    function automatic ray_test_t rand_test();
        ray_test_t t;
        int mode;
        mode = $urandom_range(9) < 2 ? 0 : ($urandom_range(9) < 1 ? 2 : 1);
        t.ray_origin_x = rand_coord(mode);
        t.ray_origin_y = rand_coord(mode);
        t.ray_origin_z = rand_coord(mode);
        t.ray_dir_x = rand_coord(mode);
        t.ray_dir_y = rand_coord(mode);
        t.ray_dir_z = rand_coord(mode);
        if (mode == 1 && $urandom_range(1))
        begin
            // centre on the ray plus jitter so hits are common
            t.centre_x = t.ray_origin_x + t.ray_dir_x * 3 + rand_coord(2) * 64;
            t.centre_y = t.ray_origin_y + t.ray_dir_y * 3 + rand_coord(2) * 64;
            t.centre_z = t.ray_origin_z + t.ray_dir_z * 3 + rand_coord(2) * 64;
        end
        else
        begin
            t.centre_x = rand_coord(mode);
            t.centre_y = rand_coord(mode);
            t.centre_z = rand_coord(mode);
        end
        t.sphere_radius = (mode == 0) ? RAD_W'($urandom) : RAD_W'($urandom_range(65536 * 30));
        t.pad = 1'b0;
        return t;
    endfunction

    function automatic ray_test_t make_test(int ox, int oy, int oz, int dx, int dy, int dz,
                                            int cx, int cy, int cz, int r);
        ray_test_t t;
        t = '{1'b0, RAD_W'(r), cz, cy, cx, dz, dy, dx, oz, oy, ox};
        return t;
    endfunction

    initial
    begin
        localparam int ONE = 65536;
        localparam int MX = 32'h7FFFFFFF;
        localparam int MN = 32'h80000000;
        int idle_src [4];
        int idle_snk [4];
        int waited;
        idle_src = '{0, 86, 0, 11};
        idle_snk = '{0, 0, 86, 11};
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: hits from outside, inside, behind, tangent, zero direction, extremes
        send_test(make_test(0, 0, 0, ONE, 0, 0, 10 * ONE, 0, 0, ONE));
        send_test(make_test(0, 0, 0, 0, 0, 0, 10 * ONE, 0, 0, ONE));
        send_test(make_test(0, 0, 0, ONE, 0, 0, 0, 0, 0, 5 * ONE));
        send_test(make_test(0, 0, 0, -ONE, 0, 0, 10 * ONE, 0, 0, ONE));
        send_test(make_test(0, 0, 0, ONE, 0, 0, 10 * ONE, 5 * ONE, 0, ONE));
        send_test(make_test(0, ONE, 0, ONE, 0, 0, 10 * ONE, 0, 0, ONE));
        send_test(make_test(0, 0, 0, 1, 0, 0, MX, 0, 0, ONE));
        send_test(make_test(MN, MN, MN, MX, MX, MX, MX, MX, MX, MX));
        send_test(make_test(MX, MX, MX, MN, MN, MN, MN, MN, MN, MX));
        send_test(make_test(MN, MX, MN, MN, MX, MN, MX, MN, MX, 0));
        send_test(make_test(-1, -1, -1, -1, -1, -1, -1, -1, -1, MX));
        send_test(make_test(0, 0, 0, 0, 0, 1, 0, 0, 0, 0));
        send_test(make_test(0, 0, 0, 0, 1, 0, 0, 0, 0, MX));
        send_test(make_test(0, 0, 0, ONE, ONE, ONE, 0, 0, 0, 0));
        send_test(make_test(5 * ONE, 0, 0, ONE, 0, 0, 0, 0, 0, ONE));
        send_test(make_test(0, 0, 0, 3, 7, 1, 100 * ONE, 200 * ONE, 50 * ONE, 20 * ONE));

        for (int ph = 0; ph < 4; ph++)
        begin
            src_idle_pct  = idle_src[ph];
            snk_stall_pct = idle_snk[ph];
            for (int i = 0; i < 160; i++)
                send_test(rand_test());
        end
        s_axis_tvalid <= 1'b0;
        snk_stall_pct = 0;

        waited = 0;
        while (sb.pending.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (150) @(posedge clk);

        $display("Checked %0d ray/sphere tests (%0d hits) over four idle/stall mixes.",
                 sb.checked, sb.hits);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb_ray_sphere_intersect OK");
        else
            $display("tb_ray_sphere_intersect NOT OK");
        $finish;
    end

    // watchdog: well beyond the slowest legal run
    initial
    begin
        #5000000;
        $display("tb_ray_sphere_intersect NOT OK");
        $finish;
    end
endmodule
`default_nettype wire

// ----- sim.f -----
hw/rtl/rsi_pkg.sv
hw/rtl/rsi_mul.sv
hw/rtl/rsi_sqrt.sv
hw/rtl/ray_sphere_intersect.sv
verif/tb_ray_sphere_intersect.sv
